[design/tlsm_pkg.sv]
// ----------------------------------------------------------------------------
// Two-list sorted merge package
// Shared types, field widths, command and register codes for the merge unit.
// ----------------------------------------------------------------------------
package tlsm_pkg;

  localparam int VALUE_W         = 32;
  localparam int KIND_W          = 2;
  localparam int LIST_DEPTH_DEF  = 16;
  localparam int CMD_QUEUE_DEPTH = 2;

  // Input kind codes as they arrive on the request port.
  localparam logic [KIND_W-1:0] KIND_PUSH_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MERGE       = 2'd2;

  // Configuration register indexes.
  localparam logic REG_DESCENDING_ORDER = 1'b0;
  localparam logic REG_SIGNED_COMPARE   = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] merged_value;
    logic               from_second;
    logic               last_of_run;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic descending_order;
    logic signed_compare;
  } cfg_t;

  // Decoded command held in the queue between front and back.
  typedef enum logic [1:0] {
    OP_PUSH_FIRST,
    OP_PUSH_SECOND,
    OP_MERGE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

[design/tlsm_front.sv]
// ----------------------------------------------------------------------------
// Merge unit front end
// Accepts requests, decodes the kind field and queues commands for the back.
// ----------------------------------------------------------------------------
module tlsm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tlsm_pkg::in_item_t in_item,
  output logic              q_valid,
  output tlsm_pkg::cmd_t    q_head,
  input  logic              q_pop
);

  localparam int QDEPTH = tlsm_pkg::CMD_QUEUE_DEPTH;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [QCNT_W-1:0] QFULL    = QCNT_W'(QDEPTH);
  localparam logic [QPTR_W-1:0] QPTR_TOP = QPTR_W'(QDEPTH - 1);

  tlsm_pkg::cmd_t    q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              cmd_ok;
  tlsm_pkg::cmd_t    cmd;
  logic              do_push;

  // Unused kind codes are accepted and dropped here.
  always_comb begin
    cmd_ok    = 1'b1;
    cmd.value = in_item.element_value;
    case (in_item.kind)
      tlsm_pkg::KIND_PUSH_FIRST:  cmd.op = tlsm_pkg::OP_PUSH_FIRST;
      tlsm_pkg::KIND_PUSH_SECOND: cmd.op = tlsm_pkg::OP_PUSH_SECOND;
      tlsm_pkg::KIND_MERGE:       cmd.op = tlsm_pkg::OP_MERGE;
      default: begin
        cmd.op = tlsm_pkg::OP_MERGE;
        cmd_ok = 1'b0;
      end
    endcase
  end

  assign busy    = (count_r == QFULL);
  assign do_push = start && !busy && cmd_ok;
  assign q_valid = (count_r != '0);
  assign q_head  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_TOP) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_TOP) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (count_r != '0))
    else $error("command queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QFULL)
    else $error("command queue count beyond depth");

endmodule

[design/tlsm_back.sv]
// ----------------------------------------------------------------------------
// Merge unit back end
// Holds both lists, executes pushes and walks the two lists during a merge.
// ----------------------------------------------------------------------------
module tlsm_back #(
  parameter int LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tlsm_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  tlsm_pkg::cmd_t     q_head,
  output logic               q_pop,
  output logic               out_valid,
  output tlsm_pkg::out_item_t out_item
);

  localparam int VW     = tlsm_pkg::VALUE_W;
  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt1_r, cnt1_nxt;
  logic [CNT_W-1:0]    cnt2_r, cnt2_nxt;
  logic [CNT_W-1:0]    p1_r, p1_nxt;
  logic [CNT_W-1:0]    p2_r, p2_nxt;
  logic                out_valid_r, out_valid_nxt;
  tlsm_pkg::out_item_t out_item_r, out_item_nxt;

  logic [VW-1:0]       mem1 [LIST_DEPTH];
  logic [VW-1:0]       mem2 [LIST_DEPTH];
  logic [VW-1:0]       head1_r, head2_r;
  logic [CNT_W-1:0]    rd1_addr, rd2_addr;
  logic                wr1_en, wr2_en;

  logic [VW-1:0]       key1, key2;
  logic                first_before;
  logic                take_first;
  logic                last;

  // Signed order is unsigned order with the sign bits flipped.
  assign key1 = head1_r ^ {cfg.signed_compare, {(VW-1){1'b0}}};
  assign key2 = head2_r ^ {cfg.signed_compare, {(VW-1){1'b0}}};
  assign first_before = cfg.descending_order ? (key1 > key2) : (key1 < key2);
  assign take_first   = (p1_r < cnt1_r) && ((p2_r >= cnt2_r) || first_before);

  always_comb begin
    state_nxt     = state_r;
    cnt1_nxt      = cnt1_r;
    cnt2_nxt      = cnt2_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    wr1_en        = 1'b0;
    wr2_en        = 1'b0;
    q_pop         = 1'b0;
    last          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_head.op)
            tlsm_pkg::OP_PUSH_FIRST: begin
              if (cnt1_r >= DEPTH_C) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{merged_value: '0, from_second: 1'b0,
                                  last_of_run: 1'b0, overflow: 1'b1};
              end else begin
                wr1_en   = 1'b1;
                cnt1_nxt = cnt1_r + 1'b1;
              end
            end
            tlsm_pkg::OP_PUSH_SECOND: begin
              if (cnt2_r >= DEPTH_C) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{merged_value: '0, from_second: 1'b1,
                                  last_of_run: 1'b0, overflow: 1'b1};
              end else begin
                wr2_en   = 1'b1;
                cnt2_nxt = cnt2_r + 1'b1;
              end
            end
            tlsm_pkg::OP_MERGE: begin
              p1_nxt = '0;
              p2_nxt = '0;
              if ((cnt1_r != '0) || (cnt2_r != '0)) begin
                state_nxt = ST_MERGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MERGE: begin
        out_valid_nxt = 1'b1;
        if (take_first) begin
          p1_nxt = p1_r + 1'b1;
          out_item_nxt.merged_value = head1_r;
          out_item_nxt.from_second  = 1'b0;
        end else begin
          p2_nxt = p2_r + 1'b1;
          out_item_nxt.merged_value = head2_r;
          out_item_nxt.from_second  = 1'b1;
        end
        last = (p1_nxt == cnt1_r) && (p2_nxt == cnt2_r);
        out_item_nxt.last_of_run = last;
        out_item_nxt.overflow    = 1'b0;
        if (last) begin
          cnt1_nxt  = '0;
          cnt2_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The read ports look at the next heads so they are ready the following cycle.
  assign rd1_addr = p1_nxt;
  assign rd2_addr = p2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt1_r      <= '0;
      cnt2_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt1_r      <= cnt1_nxt;
      cnt2_r      <= cnt2_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr1_en) begin
      mem1[cnt1_r[ADDR_W-1:0]] <= q_head.value;
    end
    if (rd1_addr < DEPTH_C) begin
      head1_r <= mem1[rd1_addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr2_en) begin
      mem2[cnt2_r[ADDR_W-1:0]] <= q_head.value;
    end
    if (rd2_addr < DEPTH_C) begin
      head2_r <= mem2[rd2_addr[ADDR_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |-> ((p1_r <= cnt1_r) && (p2_r <= cnt2_r) &&
                               ((p1_r != cnt1_r) || (p2_r != cnt2_r))))
    else $error("merge pointers ran past the list counts");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.last_of_run) |-> ((cnt1_r == '0) && (cnt2_r == '0)
                                                 && (state_r == ST_IDLE)))
    else $error("lists not emptied after the last merged value");

  a_ovf_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.overflow) |-> !out_item_r.last_of_run)
    else $error("overflow result marked as last of run");

endmodule

[design/two_list_sorted_merge_unit.sv]
// ----------------------------------------------------------------------------
// Two-list sorted merge unit
// Loads two ordered lists and emits their two-way merge on a merge request.
// ----------------------------------------------------------------------------
// Order: a taken request is first written into the command queue; the back
// end then pops it and registers any overflow result onto the ports. A merge
// with values pops into the merge state and then emits them one per cycle.
// The two-entry command queue sets when busy rises.
// Reset clears the counts, the queue and the configuration; list contents
// stay undefined until written. The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
module two_list_sorted_merge_unit #(
  parameter int LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Request channel: a request is taken when start is high and busy is low.
  input  logic                start,
  output logic                busy,
  input  tlsm_pkg::in_item_t  in_item,
  // Result channel: each result is valid for exactly one cycle.
  output logic                out_valid,
  output tlsm_pkg::out_item_t out_item,
  // Configuration write port.
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_wdata
);

  // The configuration registers must be written only while the unit is idle, so the
  // back end may read them directly during a merge; the block does not enforce this.
  tlsm_pkg::cfg_t cfg_r;
  tlsm_pkg::cmd_t q_head;
  logic           q_valid;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tlsm_pkg::REG_DESCENDING_ORDER: cfg_r.descending_order <= cfg_wdata;
        tlsm_pkg::REG_SIGNED_COMPARE:   cfg_r.signed_compare   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The front end decodes each request and queues all but the unused kind, so new
  // requests keep flowing in while the back end is still walking a merge, until the two-entry queue fills.
  tlsm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  // The back end owns both list memories and the counts. A merge reads one
  // head from each list per cycle and emits the one that orders first; ties
  // go to the second list, and once one list runs dry the other drains in order.
  tlsm_back #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[dv/two_list_sorted_merge_unit_tb.sv]
// ----------------------------------------------------------------------------
// Two-list sorted merge unit testbench
// Loads ordered lists through the request port, issues merges and compares
// every result against a predictor that tracks both lists and the ordering
// settings, or against a literal from the short directed table, which runs first;
// random phases follow under all four ordering settings with varying request gaps.
// ----------------------------------------------------------------------------
module two_list_sorted_merge_unit_tb;

  localparam int LIST_DEPTH = tlsm_pkg::LIST_DEPTH_DEF;
  localparam int VALUE_W    = tlsm_pkg::VALUE_W;
  localparam int KIND_W     = tlsm_pkg::KIND_W;
  // The fourth kind code is not decoded by the block and must be ignored.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // Cycles allowed after the last result before the block counts as idle.
  localparam int SETTLE_CYCLES  = 8;
  // Cycles with neither a request taken nor a result seen before giving up.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTED   = 10;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  tlsm_pkg::in_item_t  in_item;
  logic                out_valid;
  tlsm_pkg::out_item_t out_item;
  logic                cfg_we;
  logic                cfg_index;
  logic                cfg_wdata;

  two_list_sorted_merge_unit #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // One row of the directed stimulus. A row may repeat its request, and a
  // row whose result is obvious carries that result typed in by hand.
  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  value;
    int                  reps;
    bit                  has_literal;
    tlsm_pkg::out_item_t literal;
  } stim_row_t;

  // Predictor state: a private copy of both lists and the ordering settings.
  logic [VALUE_W-1:0] first_vals [LIST_DEPTH];
  logic [VALUE_W-1:0] second_vals[LIST_DEPTH];
  int                 first_len;
  int                 second_len;
  bit                 order_desc;
  bit                 order_signed;

  tlsm_pkg::out_item_t awaited_results[$];  // results still owed by the block, oldest first
  tlsm_pkg::out_item_t step_results[$];     // results caused by the request just taken
  stim_row_t           directed_rows[$];

  int mismatch_count;
  int idle_cycles;
  int requests_sent;
  int sender_idle_pct;

  // Free-running clock with a period of two time units.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic tlsm_pkg::out_item_t result_of(logic [VALUE_W-1:0] value,
                                                    bit second, bit is_final,
                                                    bit ovf);
    tlsm_pkg::out_item_t r;
    r.merged_value = value;
    r.from_second  = second;
    r.last_of_run  = is_final;
    r.overflow     = ovf;
    return r;
  endfunction

  // True when value a must leave the merge strictly ahead of value b under
  // the current settings. Equal values never precede each other, which is
  // what makes ties fall to the second list.
  function automatic bit precedes(logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b);
    if (order_signed) begin
      return order_desc ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
    end
    return order_desc ? (a > b) : (a < b);
  endfunction

  // Applies one taken request to the predictor state and leaves the results
  // it causes in step_results.
  task automatic predict_request(input logic [KIND_W-1:0] kind,
                                 input logic [VALUE_W-1:0] value);
    int p1;
    int p2;
    int total;
    int k;
    step_results.delete();
    case (kind)
      tlsm_pkg::KIND_PUSH_FIRST: begin
        if (first_len >= LIST_DEPTH) begin
          // A full list drops the value and flags it on the first list.
          step_results.push_back(result_of('0, 1'b0, 1'b0, 1'b1));
        end else begin
          first_vals[first_len] = value;
          first_len++;
        end
      end
      tlsm_pkg::KIND_PUSH_SECOND: begin
        if (second_len >= LIST_DEPTH) begin
          step_results.push_back(result_of('0, 1'b1, 1'b0, 1'b1));
        end else begin
          second_vals[second_len] = value;
          second_len++;
        end
      end
      tlsm_pkg::KIND_MERGE: begin
        p1    = 0;
        p2    = 0;
        k     = 0;
        total = first_len + second_len;
        // Take the first head only when it strictly precedes the second
        // head; once a list runs dry the other one drains in order.
        while (p1 < first_len || p2 < second_len) begin
          if (p1 < first_len &&
              (p2 >= second_len || precedes(first_vals[p1], second_vals[p2]))) begin
            step_results.push_back(result_of(first_vals[p1], 1'b0, k + 1 == total, 1'b0));
            p1++;
          end else begin
            step_results.push_back(result_of(second_vals[p2], 1'b1, k + 1 == total, 1'b0));
            p2++;
          end
          k++;
        end
        first_len  = 0;
        second_len = 0;
      end
      default: begin
      end
    endcase
  endtask

  // Drives one request and holds it until the block takes it. The sender
  // may first go quiet, at the rate set for the phase.
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [VALUE_W-1:0] value,
                              input bit has_literal,
                              input tlsm_pkg::out_item_t literal);
    tlsm_pkg::in_item_t req;
    req.kind          = kind;
    req.element_value = value;
    while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Taken at this edge: busy was low with start high.
    predict_request(kind, value);
    if (has_literal) begin
      awaited_results.push_back(literal);
    end else begin
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    end
    if (kind != KIND_UNUSED) requests_sent++;
  endtask

  // Stops sending, waits for every owed result and then lets the block run
  // out whatever pushes may still sit in its command queue.
  task automatic drain_and_settle();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both ordering registers, descending order first, then signed compare. Only called
  // while the block is idle.
  task automatic program_order(input bit desc, input bit sgn);
    cfg_we    <= 1'b1;
    cfg_index <= tlsm_pkg::REG_DESCENDING_ORDER;
    cfg_wdata <= desc;
    @(posedge clk);
    cfg_index <= tlsm_pkg::REG_SIGNED_COMPARE;
    cfg_wdata <= sgn;
    @(posedge clk);
    cfg_we       <= 1'b0;
    order_desc   = desc;
    order_signed = sgn;
  endtask

  function automatic void add_row(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
                                  int reps, bit has_literal,
                                  tlsm_pkg::out_item_t literal);
    stim_row_t row;
    row.kind        = kind;
    row.value       = value;
    row.reps        = reps;
    row.has_literal = has_literal;
    row.literal     = literal;
    directed_rows.push_back(row);
  endfunction

  // Random element values: full-range words, the signed and unsigned
  // boundaries, and small values around zero so that ties and sign flips
  // are common.
  function automatic logic [VALUE_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return $urandom;
    if (roll < 7) begin
      case ($urandom_range(0, 4))
        0:       return 32'h0000_0000;
        1:       return 32'h0000_0001;
        2:       return 32'h7FFF_FFFF;
        3:       return 32'h8000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return 32'($urandom_range(0, 15)) - 32'd8;
  endfunction

  // Mostly short lists, sometimes medium ones and now and then a full one.
  function automatic int pick_len();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return $urandom_range(0, 4);
    if (roll < 9) return $urandom_range(5, LIST_DEPTH - 1);
    return LIST_DEPTH;
  endfunction

  // Builds a list of n values already ordered under the current settings.
  task automatic make_ordered_list(input int n, ref logic [VALUE_W-1:0] vals[$]);
    logic [VALUE_W-1:0] tmp;
    int                 i;
    int                 j;
    vals.delete();
    for (i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 4) == 0) vals.push_back(vals[i - 1]);
      else vals.push_back(pick_value());
    end
    for (i = 1; i < n; i++) begin
      j = i;
      while (j > 0 && precedes(vals[j], vals[j - 1])) begin
        tmp         = vals[j];
        vals[j]     = vals[j - 1];
        vals[j - 1] = tmp;
        j--;
      end
    end
  endtask

  // Random part of one phase. Most of it loads two properly ordered lists
  // in a random interleaving and merges them; the rest is unordered or
  // stray pushes, lone merges (often empty) and the unused kind.
  task automatic run_random_phase(input int target);
    logic [VALUE_W-1:0] seq_a[$];
    logic [VALUE_W-1:0] seq_b[$];
    int                 sent_before;
    int                 roll;
    int                 i1;
    int                 i2;
    int                 n;
    sent_before = requests_sent;
    while (requests_sent - sent_before < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        make_ordered_list(pick_len(), seq_a);
        make_ordered_list(pick_len(), seq_b);
        i1 = 0;
        i2 = 0;
        while (i1 < seq_a.size() || i2 < seq_b.size()) begin
          if (i2 >= seq_b.size() || (i1 < seq_a.size() && $urandom_range(0, 1) == 0)) begin
            send_request(tlsm_pkg::KIND_PUSH_FIRST, seq_a[i1], 1'b0, '0);
            i1++;
          end else begin
            send_request(tlsm_pkg::KIND_PUSH_SECOND, seq_b[i2], 1'b0, '0);
            i2++;
          end
        end
        // A full list sometimes gets one or two more pushes, which must
        // come back as overflow results.
        if (seq_a.size() == LIST_DEPTH && $urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            send_request(tlsm_pkg::KIND_PUSH_FIRST, $urandom, 1'b0, '0);
          end
        end
        if (seq_b.size() == LIST_DEPTH && $urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            send_request(tlsm_pkg::KIND_PUSH_SECOND, $urandom, 1'b0, '0);
          end
        end
        send_request(tlsm_pkg::KIND_MERGE, $urandom, 1'b0, '0);
      end else if (roll < 90) begin
        n = $urandom_range(1, 6);
        repeat (n) send_request(2'($urandom_range(0, 3)), $urandom, 1'b0, '0);
        if ($urandom_range(0, 1) == 0) send_request(tlsm_pkg::KIND_MERGE, $urandom, 1'b0, '0);
      end else if (roll < 95) begin
        send_request(tlsm_pkg::KIND_MERGE, $urandom, 1'b0, '0);
      end else begin
        send_request(KIND_UNUSED, $urandom, 1'b0, '0);
      end
    end
  endtask

  // Result checking and the watchdog. Both look at values sampled at the
  // rising edge, so they see what the block presented during the cycle
  // that just ended.
  always @(posedge clk) begin
    tlsm_pkg::out_item_t want;
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED) begin
            $display("ERROR: unexpected result value=%h second=%b last=%b ovf=%b",
                     out_item.merged_value, out_item.from_second,
                     out_item.last_of_run, out_item.overflow);
          end
        end else begin
          want = awaited_results.pop_front();
          if (out_item.merged_value !== want.merged_value ||
              out_item.from_second  !== want.from_second  ||
              out_item.last_of_run  !== want.last_of_run  ||
              out_item.overflow     !== want.overflow) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED) begin
              $display("ERROR: result mismatch: expected value=%h second=%b last=%b ovf=%b",
                       want.merged_value, want.from_second, want.last_of_run,
                       want.overflow);
              $display("       actual value=%h second=%b last=%b ovf=%b",
                       out_item.merged_value, out_item.from_second,
                       out_item.last_of_run, out_item.overflow);
            end
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no request taken and no result seen for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int ph;
    int r;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    cfg_we          = 1'b0;
    cfg_index       = 1'b0;
    cfg_wdata       = 1'b0;
    first_len       = 0;
    second_len      = 0;
    order_desc      = 1'b0;
    order_signed    = 1'b0;
    mismatch_count  = 0;
    idle_cycles     = 0;
    requests_sent   = 0;
    sender_idle_pct = 9;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, run with ascending unsigned order. Literal results
    // are the ones that follow directly from reset or from a full list.
    // A merge with both lists empty yields nothing, and so does the
    // unused kind.
    add_row(tlsm_pkg::KIND_MERGE,       32'h0000_0000, 1, 1'b0, '0);
    add_row(KIND_UNUSED,                32'hFFFF_FFFF, 1, 1'b0, '0);
    // Single-element merges, one from each list.
    add_row(tlsm_pkg::KIND_PUSH_FIRST,  32'h0000_0000, 1, 1'b0, '0);
    add_row(tlsm_pkg::KIND_MERGE,       32'hFFFF_FFFF, 1, 1'b1,
            result_of(32'h0, 1'b0, 1'b1, 1'b0));
    add_row(tlsm_pkg::KIND_PUSH_SECOND, 32'hFFFF_FFFF, 1, 1'b0, '0);
    add_row(tlsm_pkg::KIND_MERGE,       32'h0000_0000, 1, 1'b1,
            result_of(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0));
    // Equal heads: the second list goes first.
    add_row(tlsm_pkg::KIND_PUSH_FIRST,  32'h0000_0005, 1, 1'b0, '0);
    add_row(tlsm_pkg::KIND_PUSH_SECOND, 32'h0000_0005, 1, 1'b0, '0);
    add_row(tlsm_pkg::KIND_MERGE,       32'h0000_0000, 1, 1'b0, '0);
    // Values at the sign boundary, with an ignored request in the middle.
    add_row(tlsm_pkg::KIND_PUSH_FIRST,  32'h0000_0001, 1, 1'b0, '0);
    add_row(tlsm_pkg::KIND_PUSH_FIRST,  32'h7FFF_FFFF, 1, 1'b0, '0);
    add_row(tlsm_pkg::KIND_PUSH_SECOND, 32'h8000_0000, 1, 1'b0, '0);
    add_row(KIND_UNUSED,                32'hA5A5_A5A5, 1, 1'b0, '0);
    add_row(tlsm_pkg::KIND_PUSH_SECOND, 32'hFFFF_FFFE, 1, 1'b0, '0);
    add_row(tlsm_pkg::KIND_MERGE,       32'h5A5A_5A5A, 1, 1'b0, '0);
    // Fill both lists, push once more into each, then merge the largest run.
    add_row(tlsm_pkg::KIND_PUSH_FIRST,  32'hFFFF_FFFF, LIST_DEPTH, 1'b0, '0);
    add_row(tlsm_pkg::KIND_PUSH_FIRST,  32'h1234_5678, 1, 1'b1,
            result_of(32'h0, 1'b0, 1'b0, 1'b1));
    add_row(tlsm_pkg::KIND_PUSH_SECOND, 32'h0000_0000, LIST_DEPTH, 1'b0, '0);
    add_row(tlsm_pkg::KIND_PUSH_SECOND, 32'hFFFF_FFFF, 1, 1'b1,
            result_of(32'h0, 1'b1, 1'b0, 1'b1));
    add_row(tlsm_pkg::KIND_MERGE,       32'h0000_0000, 1, 1'b0, '0);

    program_order(1'b0, 1'b0);
    foreach (directed_rows[i]) begin
      for (r = 0; r < directed_rows[i].reps; r++) begin
        send_request(directed_rows[i].kind, directed_rows[i].value,
                     directed_rows[i].has_literal, directed_rows[i].literal);
      end
    end
    drain_and_settle();

    // Random phases walk through all four ordering settings. The sender
    // idles rarely, then often, then never.
    for (ph = 0; ph < 6; ph++) begin
      sender_idle_pct = (ph < 2) ? 9 : (ph < 4) ? 47 : 0;
      program_order(ph[0], ph[1]);
      run_random_phase(28);
      drain_and_settle();
    end

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
